// ===== hw/rtl/local_maximum_3x3_detector_top_defines.svh =====
// Assertion macros used by the local maximum detector top module.
`ifndef LOCAL_MAXIMUM_3X3_DETECTOR_TOP_DEFINES_SVH
`define LOCAL_MAXIMUM_3X3_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked while in reset
`define LMD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, masked while in reset
`define LMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lmd_pkg.sv =====
package lmd_pkg;

	// register map of the configuration port
	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	// item kinds carried in tuser
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam int CFG_BITS     = 11;
	localparam int ROW_CNT_BITS = 11;
	localparam int POS_BITS     = 10;
	localparam int MAX_HEIGHT   = 1024;
	localparam int NEIGHBOURS   = 8;

	// which sides of the centre lie inside the frame
	typedef struct packed {
		logic has_up;
		logic has_down;
		logic has_left;
		logic has_right;
	} nbr_ok_t;

endpackage

// ===== hw/rtl/lmd_ram.sv =====
module lmd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port; read returns old data on collision
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/lmd_peak.sv =====
module lmd_peak #(
	parameter int PIXEL_BITS = 16
) (
	input  logic [2:0][2:0][PIXEL_BITS-1:0] win,
	input  lmd_pkg::nbr_ok_t                nbr,
	output logic                            is_peak
);

	logic [lmd_pkg::NEIGHBOURS-1:0] beaten;

	// a neighbour inside the frame that is not below the centre kills the peak
	for (genvar gr = 0; gr < 3; gr++) begin : g_row
		for (genvar gc = 0; gc < 3; gc++) begin : g_col
			if (!(gr == 1 && gc == 1)) begin : g_nbr
				localparam int K = (gr * 3 + gc > 4) ? gr * 3 + gc - 1 : gr * 3 + gc;
				logic in_frame;
				assign in_frame = ((gr != 0) || nbr.has_up) && ((gr != 2) || nbr.has_down)
					&& ((gc != 0) || nbr.has_left) && ((gc != 2) || nbr.has_right);
				assign beaten[K] = in_frame && ($signed(win[gr][gc]) >= $signed(win[1][1]));
			end
		end
	end

	assign is_peak = (beaten == '0);

endmodule

// ===== hw/rtl/local_maximum_3x3_detector_top.sv =====
// 3x3 strict local maximum detector.
// Slave stream: one sample per word, tdata = pixel (signed), tuser = op
// (pixel or flush). Send frame_width*frame_height samples in raster order,
// then frame_width+1 flush words; position counters then wrap for the next frame.
// Master stream: one word per peak, tdata = peak_value, peak_row, peak_col,
// in raster order of the peaks.
// Throughput: one word per cycle while s_axis_tready is high. The two line stores
// share one RAM that is read and written once per word; a write-to-read forward
// covers a repeated column. A peak word is built from the stage 1 registers and
// held in the output register, frame_width+1 words after the peak pixel itself.
// The user writes configuration (frame_width, frame_height) only while idle; the
// block does not enforce it. Zero acts as one; oversize values clamp to maximum.
// Reset clears the counters, the window and the handshake state; the line
// store RAM is not cleared and needs no clearing pass.
// When the master side stalls, the input keeps flowing until a second peak
// is ready; then s_axis_tready drops until the held word is taken.
module local_maximum_3x3_detector_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [0:0]                    cfg_index,
	input  logic [lmd_pkg::CFG_BITS-1:0]  cfg_data,
	// sample stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0] s_axis_tdata,  // pixel
	input  logic [0:0]                    s_axis_tuser,  // op
	// peak stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// peak_value, peak_row, peak_col
	output logic [((PIXEL_BITS+2*lmd_pkg::POS_BITS+7)/8)*8-1:0] m_axis_tdata
);

	`include "local_maximum_3x3_detector_top_defines.svh"

	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int WBITS   = CW + 1;
	localparam int RB      = lmd_pkg::ROW_CNT_BITS;
	localparam int PB      = PIXEL_BITS;
	localparam int PO      = lmd_pkg::POS_BITS;
	localparam int OUT_W   = ((PB + 2 * PO + 7) / 8) * 8;
	localparam int W_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

	// configuration, stored clamped
	logic [WBITS-1:0] w_q;
	logic [RB-1:0]    h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WBITS'(W_RESET);
			h_q <= RB'(lmd_pkg::MAX_HEIGHT);
		end else if (cfg_wr_en) begin
			unique case (lmd_pkg::cfg_idx_t'(cfg_index))
				lmd_pkg::CFG_FRAME_WIDTH: begin
					if (cfg_data == '0) begin
						w_q <= WBITS'(1);
					end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
						w_q <= WBITS'(MAX_WIDTH);
					end else begin
						w_q <= WBITS'(cfg_data);
					end
				end
				lmd_pkg::CFG_FRAME_HEIGHT: begin
					if (cfg_data == '0) begin
						h_q <= RB'(1);
					end else if (32'(cfg_data) > 32'(lmd_pkg::MAX_HEIGHT)) begin
						h_q <= RB'(lmd_pkg::MAX_HEIGHT);
					end else begin
						h_q <= RB'(cfg_data);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline state
	logic [CW-1:0]     c_q;
	logic [RB-1:0]     r_q;
	logic              v_s1;
	logic [CW-1:0]     c_s1;
	logic [RB-1:0]     r_s1;
	logic [PB-1:0]     val_s1;
	logic              fwd_s1;
	logic [2*PB-1:0]   fwd_data_s1;
	logic [2:0][2:0][PB-1:0] win_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic              en;
	logic              accept;
	logic [2*PB-1:0]   ram_rdata;
	logic [2*PB-1:0]   rd_eff;
	logic [PB-1:0]     up_cur;
	logic [PB-1:0]     mid_cur;
	logic [2*PB-1:0]   wr_data;
	logic [2:0][2:0][PB-1:0] win_new;
	logic [2:0][2:0][PB-1:0] win_a;
	lmd_pkg::nbr_ok_t  nbr_a;
	lmd_pkg::nbr_ok_t  nbr_b;
	logic              peak_a;
	logic              peak_b;
	logic              hit_a;
	logic              hit_b;
	logic              hit;
	logic              frame_end;
	logic              col_last;
	logic [RB:0]       h_p1;

	// stall only when a new peak meets a held, untaken word
	assign en            = !(v_s1 && hit && m_tvalid_q && !m_axis_tready);
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	// line stores: upper in the high half, middle in the low half
	assign rd_eff  = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign up_cur  = rd_eff[2*PB-1:PB];
	assign mid_cur = rd_eff[PB-1:0];
	assign wr_data = {mid_cur, val_s1};

	lmd_ram #(
		.WIDTH (2 * PB),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (v_s1 && en),
		.wr_addr (c_s1),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (c_q),
		.rd_data (ram_rdata)
	);

	// position counters of the incoming word
	assign h_p1      = {1'b0, h_q} + (RB+1)'(1);
	assign frame_end = {1'b0, r_q} >= h_p1;
	assign col_last  = ({1'b0, c_q} + WBITS'(1)) >= w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				c_q <= '0;
				r_q <= '0;
			end else if (col_last) begin
				c_q <= '0;
				r_q <= r_q + RB'(1);
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end

	// stage 1 registers: word in flight while its line data is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1        <= c_q;
			r_s1        <= r_q;
			val_s1      <= (s_axis_tuser[0] == lmd_pkg::OP_FLUSH) ? '0 : s_axis_tdata[PB-1:0];
			fwd_s1      <= v_s1 && (c_s1 == c_q);
			fwd_data_s1 <= wr_data;
		end
	end

	// window after this word shifts in, and the unshifted view for the row-end check
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_new[k][0] = win_q[k][1];
			win_new[k][1] = win_q[k][2];
			win_a[k][0]   = win_q[k][1];
			win_a[k][1]   = win_q[k][2];
			win_a[k][2]   = win_q[k][2];
		end
		win_new[0][2] = up_cur;
		win_new[1][2] = mid_cur;
		win_new[2][2] = val_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1 && en) begin
			win_q <= win_new;
		end
	end

	// last pixel of the row two above, decided at column zero
	assign nbr_a.has_up    = r_s1 >= RB'(3);
	assign nbr_a.has_down  = r_s1 <= h_q;
	assign nbr_a.has_left  = w_q >= WBITS'(2);
	assign nbr_a.has_right = 1'b0;
	assign hit_a = (c_s1 == '0) && (r_s1 >= RB'(2)) && ({1'b0, r_s1} <= h_p1) && peak_a;

	// pixel one row up and one column left of the incoming word
	assign nbr_b.has_up    = r_s1 >= RB'(2);
	assign nbr_b.has_down  = r_s1 < h_q;
	assign nbr_b.has_left  = c_s1 >= CW'(2);
	assign nbr_b.has_right = {1'b0, c_s1} < w_q;
	assign hit_b = (c_s1 != '0) && (r_s1 != '0) && (r_s1 <= h_q) && ({1'b0, c_s1} <= w_q)
		&& peak_b;

	assign hit = hit_a || hit_b;

	lmd_peak #(.PIXEL_BITS(PB)) u_peak_a (
		.win     (win_a),
		.nbr     (nbr_a),
		.is_peak (peak_a)
	);

	lmd_peak #(.PIXEL_BITS(PB)) u_peak_b (
		.win     (win_new),
		.nbr     (nbr_b),
		.is_peak (peak_b)
	);

	// output register; both checks take the same centre cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (v_s1 && hit && en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && hit && en) begin
			if (hit_a) begin
				m_tdata_q <= OUT_W'({PO'(32'(w_q) - 32'd1), PO'(r_s1 - RB'(2)), win_q[1][2]});
			end else begin
				m_tdata_q <= OUT_W'({PO'(32'(c_s1) - 32'd1), PO'(r_s1 - RB'(1)), win_q[1][2]});
			end
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	`LMD_ASSERT_NOW(a_one_check, v_s1, !(hit_a && hit_b), "both peak checks fired for one word")
	`LMD_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_tvalid_q && !m_axis_tready && hit,
		"input stalled without a blocked peak")
	`LMD_ASSERT_NOW(a_row_bound, 1'b1, 32'(r_q) <= 32'(lmd_pkg::MAX_HEIGHT + 1),
		"row counter ran past the frame")
	`LMD_ASSERT_NEXT(a_peak_loaded, v_s1 && hit && en, m_tvalid_q, "peak not loaded")

endmodule

// ===== tb/lmd_peak_checker.sv =====
// Watches both streams and the configuration port of the local maximum
// detector, tracks the window state itself and checks every peak word.
module lmd_peak_checker
	import lmd_pkg::*;
#(
	parameter int LINE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // pixel
	input  logic [0:0]  s_axis_tuser,   // op
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,   // peak_value, peak_row, peak_col
	output int          failures,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] value;
		logic [9:0]         row;
		logic [9:0]         col;
	} peak_t;

	peak_t              expected_peaks [$];
	logic signed [15:0] upper_line [LINE_DEPTH];
	logic signed [15:0] middle_line [LINE_DEPTH];
	logic signed [15:0] win [3][3];
	logic [10:0]        width_reg;
	logic [10:0]        height_reg;
	int                 row_cnt;
	int                 col_cnt;

	initial begin
		failures    = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what);
		failures++;
		if (failures <= 40)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// strict maximum against the in-frame neighbours held in the window
	function automatic bit peak_at(int cx, int crow, int ccol, int w, int h);
		logic signed [15:0] centre;
		centre = win[1][cx];
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				if (dr == 0 && dc == 0)
					continue;
				if (crow + dr < 0 || crow + dr >= h || ccol + dc < 0 || ccol + dc >= w)
					continue;
				if (cx + dc < 0 || cx + dc > 2)
					continue;
				if (win[1 + dr][cx + dc] >= centre)
					return 0;
			end
		end
		return 1;
	endfunction

	task automatic record_peak(input int cx, input int row, input int col);
		peak_t hit;
		hit.value = win[1][cx];
		hit.row   = row[9:0];
		hit.col   = col[9:0];
		expected_peaks.push_back(hit);
	endtask

	// one accepted sample word: line stores, window shift, decisions, counters
	task automatic advance_window(input logic op, input logic [15:0] pix);
		int                 w;
		int                 h;
		int                 r;
		int                 c;
		logic signed [15:0] sample;
		logic signed [15:0] up_s;
		logic signed [15:0] mid_s;
		w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg));
		h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
		r = row_cnt;
		c = col_cnt;
		sample = (op == OP_FLUSH) ? 16'sd0 : $signed(pix);
		up_s = '0;
		mid_s = '0;

		// last pixel of the row two above is decided at column zero
		if (c == 0 && r >= 2 && r - 2 < h && peak_at(2, r - 2, w - 1, w, h))
			record_peak(2, r - 2, w - 1);

		if (c < LINE_DEPTH) begin
			up_s = upper_line[c];
			mid_s = middle_line[c];
			upper_line[c] = mid_s;
			middle_line[c] = sample;
		end
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = up_s;
		win[1][2] = mid_s;
		win[2][2] = sample;

		if (c >= 1 && r >= 1 && r - 1 < h && c - 1 < w && peak_at(1, r - 1, c - 1, w, h))
			record_peak(1, r - 1, c - 1);

		if (r >= h + 1) begin
			row_cnt = 0;
			col_cnt = 0;
		end else if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		peak_t want;
		if (!arst_n) begin
			width_reg  = 11'd1024;
			height_reg = 11'd1024;
			row_cnt    = 0;
			col_cnt    = 0;
			for (int i = 0; i < LINE_DEPTH; i++) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win[i][j] = '0;
			expected_peaks.delete();
			outstanding <= 0;
		end else begin
			// peak word against the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_peaks.size() == 0) begin
					report_mismatch($sformatf("unexpected peak word %h", m_axis_tdata));
				end else begin
					want = expected_peaks.pop_front();
					if (m_axis_tdata[15:0] !== want.value)
						report_mismatch($sformatf("peak_value %0d, want %0d",
							$signed(m_axis_tdata[15:0]), want.value));
					if (m_axis_tdata[25:16] !== want.row)
						report_mismatch($sformatf("peak_row %0d, want %0d",
							m_axis_tdata[25:16], want.row));
					if (m_axis_tdata[35:26] !== want.col)
						report_mismatch($sformatf("peak_col %0d, want %0d",
							m_axis_tdata[35:26], want.col));
				end
			end

			if (cfg_wr_en) begin
				if (cfg_index == CFG_FRAME_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == CFG_FRAME_HEIGHT)
					height_reg = cfg_data;
			end

			if (s_axis_tvalid && s_axis_tready)
				advance_window(s_axis_tuser[0], s_axis_tdata);

			outstanding <= expected_peaks.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Stimulus and verdict for the local maximum detector; checking lives in
// the peak checker instantiated beside the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASE_ITEMS  = 80;
	localparam int LINE_DEPTH   = 1024;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [0:0]  cfg_index = lmd_pkg::CFG_FRAME_WIDTH;
	logic [10:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // pixel
	logic [0:0]  s_axis_tuser = lmd_pkg::OP_PIXEL;   // op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // peak_value, peak_row, peak_col

	int failures;
	int outstanding;
	int cycle_count = 0;
	int tx_idle_pct = 14;
	int rx_idle_pct = 87;

	local_maximum_3x3_detector_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	lmd_peak_checker #(.LINE_DEPTH(LINE_DEPTH)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

	// hold a word until taken, with random gaps in front of it
	task automatic send_word(input logic op, input logic [15:0] pix);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop sending and let every expected peak come out
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_frame(input logic [10:0] w_reg, input logic [10:0] h_reg);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= lmd_pkg::CFG_FRAME_WIDTH;
		cfg_data  <= w_reg;
		@(posedge clk);
		cfg_index <= lmd_pkg::CFG_FRAME_HEIGHT;
		cfg_data  <= h_reg;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// one whole frame plus its flush tail; broken frames mix up the ops
	task automatic run_frame(input logic [10:0] w_reg, input logic [10:0] h_reg,
			input int mode, input bit broken, output int pixel_words);
		int          w;
		int          h;
		int          total;
		logic        op;
		logic [15:0] pix;
		w = (w_reg == 0) ? 1 : ((w_reg > LINE_DEPTH) ? LINE_DEPTH : int'(w_reg));
		h = (h_reg == 0) ? 1 :
			((h_reg > lmd_pkg::MAX_HEIGHT) ? lmd_pkg::MAX_HEIGHT : int'(h_reg));
		total = w * (h + 1) + 1;
		pixel_words = w * h;
		set_frame(w_reg, h_reg);
		for (int i = 0; i < total; i++) begin
			op = (i < pixel_words) ? lmd_pkg::OP_PIXEL : lmd_pkg::OP_FLUSH;
			if (broken && $urandom_range(0, 3) == 0)
				op = ~op;
			case (mode)
				0: pix = 16'($urandom_range(0, 65535));
				1: pix = 16'($urandom_range(0, 3));
				2: pix = 16'h8000 + 16'($urandom_range(0, 3));
				default: pix = 16'h7fff - 16'($urandom_range(0, 3));
			endcase
			send_word(op, pix);
		end
	endtask

	initial begin
		int phase_words;
		int words;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3: full-scale centre peak, ties, flush inside the frame,
		// a pixel in the tail that must be ignored
		set_frame(11'd3, 11'd3);
		send_word(lmd_pkg::OP_PIXEL, 16'h8000); send_word(lmd_pkg::OP_PIXEL, 16'd5);
		send_word(lmd_pkg::OP_PIXEL, 16'h8000);
		send_word(lmd_pkg::OP_PIXEL, 16'd7);    send_word(lmd_pkg::OP_PIXEL, 16'h7fff);
		send_word(lmd_pkg::OP_PIXEL, 16'd7);
		send_word(lmd_pkg::OP_FLUSH, 16'hffff); send_word(lmd_pkg::OP_PIXEL, 16'd7);
		send_word(lmd_pkg::OP_PIXEL, 16'd0);
		send_word(lmd_pkg::OP_FLUSH, 16'd0);    send_word(lmd_pkg::OP_PIXEL, 16'h7fff);
		send_word(lmd_pkg::OP_FLUSH, 16'd0);    send_word(lmd_pkg::OP_FLUSH, 16'd0);
		// single column
		set_frame(11'd1, 11'd3);
		send_word(lmd_pkg::OP_PIXEL, 16'd3);    send_word(lmd_pkg::OP_PIXEL, 16'hffff);
		send_word(lmd_pkg::OP_PIXEL, 16'd2);
		send_word(lmd_pkg::OP_FLUSH, 16'd0);    send_word(lmd_pkg::OP_FLUSH, 16'd0);
		// single row of negatives
		set_frame(11'd2, 11'd1);
		send_word(lmd_pkg::OP_PIXEL, 16'hfffb); send_word(lmd_pkg::OP_PIXEL, 16'hfffa);
		send_word(lmd_pkg::OP_FLUSH, 16'd0);    send_word(lmd_pkg::OP_FLUSH, 16'd0);
		send_word(lmd_pkg::OP_FLUSH, 16'd0);

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 14 : ((phase == 1) ? 87 : 0);
			rx_idle_pct = (phase == 0) ? 87 : ((phase == 1) ? 14 : 0);

			// one tall single-column frame, both registers out of range
			if (phase == 0)
				run_frame(11'd0, 11'd2047, 0, 1'b0, words);

			phase_words = 0;
			while (phase_words < PHASE_ITEMS) begin
				run_frame(($urandom_range(0, 19) == 0) ? 11'd0 : 11'($urandom_range(1, 16)),
					($urandom_range(0, 19) == 0) ? 11'd0 : 11'($urandom_range(1, 10)),
					$urandom_range(0, 3), ($urandom_range(0, 9) == 0), words);
				phase_words += words;
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
